/* hdl/dhrs_pkg.sv */
// Shared types and constants for the device health retry supervisor.
package dhrs_pkg;

  localparam int unsigned SLOTS      = 16;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned ERR_W      = 16;
  localparam int unsigned RETRY_W    = 3;
  localparam int unsigned FAULT_W    = 8;
  localparam int unsigned BACKOFF_W  = 16;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [RETRY_W-1:0]   MaxRetriesRst  = 3'd3;
  localparam logic [BACKOFF_W-1:0] BaseBackoffRst = 16'd1000;

  typedef enum logic [1:0] {
    OP_REGISTER = 2'd0,
    OP_INIT     = 2'd1,
    OP_CHECK    = 2'd2,
    OP_REMOVE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_EMPTY       = 3'd0,
    ST_UNKNOWN     = 3'd1,
    ST_CONFIGURING = 3'd2,
    ST_AVAILABLE   = 3'd3,
    ST_UNAVAILABLE = 3'd4,
    ST_ERROR       = 3'd5,
    ST_REMOVED     = 3'd6
  } state_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_RETRIES  = 1'd0,
    CFG_BASE_BACKOFF = 1'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [RETRY_W-1:0]   max_retries;
    logic [BACKOFF_W-1:0] base_backoff_ms;
  } dhrs_cfg_t;

  typedef struct packed {
    logic [1:0]        operation;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] current_time_ms;
    logic              health_ok;
    logic              init_ok;
    logic [ERR_W-1:0]  error_code;
  } dhrs_req_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  result_slot;
    logic               done_res;
    logic [2:0]         old_state;
    logic [2:0]         new_state;
    logic               reinit_attempted;
    logic               retries_exhausted;
    logic [RETRY_W-1:0] retry_count;
    logic [FAULT_W-1:0] fault_count;
    logic [ERR_W-1:0]   last_error;
    logic [COUNT_W-1:0] device_count;
  } dhrs_rsp_t;

endpackage

/* hdl/dhrs_if.sv */
// Valid/ready channel interfaces for request and result words.
interface dhrs_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [3:0]  slot;
  logic [31:0] current_time_ms;
  logic        health_ok;
  logic        init_ok;
  logic [15:0] error_code;

  modport source (output valid, operation, slot, current_time_ms, health_ok, init_ok,
                  error_code, input ready);
  modport sink (input valid, operation, slot, current_time_ms, health_ok, init_ok,
                error_code, output ready);
endinterface

interface dhrs_rsp_if;
  logic        valid;
  logic        ready;
  logic [3:0]  result_slot;
  logic        done_res;
  logic [2:0]  old_state;
  logic [2:0]  new_state;
  logic        reinit_attempted;
  logic        retries_exhausted;
  logic [2:0]  retry_count;
  logic [7:0]  fault_count;
  logic [15:0] last_error;
  logic [4:0]  device_count;

  modport source (output valid, result_slot, done_res, old_state, new_state,
                  reinit_attempted, retries_exhausted, retry_count, fault_count,
                  last_error, device_count, input ready);
  modport sink (input valid, result_slot, done_res, old_state, new_state,
                reinit_attempted, retries_exhausted, retry_count, fault_count,
                last_error, device_count, output ready);
endinterface

/* hdl/device_health_retry_supervisor.sv */
// Top level: request register, slot supervisor and result register.
// Path: an accepted word is held in the request register, where its result is computed
// and the slot table updated; the result then moves into the result register and is offered.
// Throughput: one word per cycle while the result channel takes words; the request register
// and the result register advance together and hold while stalled, and each word updates
// the slot table as it leaves the request register.
// Reset: rst_ni clears all slots, the device count and both handshake stages, and sets
// max_retries to 3 and base_backoff_ms to 1000.
module device_health_retry_supervisor
  import dhrs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  dhrs_req_if.sink              req_i,
  dhrs_rsp_if.source            rsp_o
);

  dhrs_cfg_t cfg_q;
  dhrs_req_t req_q, req_d;
  dhrs_rsp_t rsp_q, rsp_d;
  logic      req_vld_q;
  logic      rsp_vld_q;
  logic      advance;
  logic      fire;

  // Result stage drains or is empty: move everything forward
  assign advance     = !rsp_vld_q || rsp_o.ready;
  assign fire        = req_vld_q && advance;
  assign req_i.ready = advance;

  assign req_d.operation       = req_i.operation;
  assign req_d.slot            = req_i.slot;
  assign req_d.current_time_ms = req_i.current_time_ms;
  assign req_d.health_ok       = req_i.health_ok;
  assign req_d.init_ok         = req_i.init_ok;
  assign req_d.error_code      = req_i.error_code;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_retries     <= MaxRetriesRst;
      cfg_q.base_backoff_ms <= BaseBackoffRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MAX_RETRIES:  cfg_q.max_retries     <= cfg_wdata_i[RETRY_W-1:0];
        CFG_BASE_BACKOFF: cfg_q.base_backoff_ms <= cfg_wdata_i[BACKOFF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  dhrs_supervisor u_supervisor (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .req_i  (req_q),
    .cfg_i  (cfg_q),
    .rsp_o  (rsp_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      rsp_vld_q <= 1'b0;
    end else if (advance) begin
      req_vld_q <= req_i.valid;
      rsp_vld_q <= req_vld_q;
    end
  end

  // Payload: hold while stalled
  always_ff @(posedge clk_i) begin
    if (advance) begin
      req_q <= req_d;
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid             = rsp_vld_q;
  assign rsp_o.result_slot       = rsp_q.result_slot;
  assign rsp_o.done_res          = rsp_q.done_res;
  assign rsp_o.old_state         = rsp_q.old_state;
  assign rsp_o.new_state         = rsp_q.new_state;
  assign rsp_o.reinit_attempted  = rsp_q.reinit_attempted;
  assign rsp_o.retries_exhausted = rsp_q.retries_exhausted;
  assign rsp_o.retry_count       = rsp_q.retry_count;
  assign rsp_o.fault_count       = rsp_q.fault_count;
  assign rsp_o.last_error        = rsp_q.last_error;
  assign rsp_o.device_count      = rsp_q.device_count;

endmodule

/* hdl/dhrs_supervisor.sv */
// Slot table with per-slot life-cycle state and its combinational update logic.
module dhrs_supervisor
  import dhrs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  dhrs_req_t req_i,
  input  dhrs_cfg_t cfg_i,
  output dhrs_rsp_t rsp_o
);

  logic [SLOTS-1:0]   used_q;
  logic [2:0]         status_q [SLOTS];
  logic [RETRY_W-1:0] retry_q  [SLOTS];
  logic [TIME_W-1:0]  due_q    [SLOTS];
  logic [ERR_W-1:0]   err_q    [SLOTS];
  logic [FAULT_W-1:0] fault_q  [SLOTS];
  logic [COUNT_W-1:0] count_q, count_d;

  op_e               op;
  logic              free_found;
  logic [SLOT_W-1:0] free_idx;
  logic [SLOT_W-1:0] idx;
  logic              hit;
  logic              in_range;

  logic               rd_used;
  logic [2:0]         rd_st;
  logic [RETRY_W-1:0] rd_rt;
  logic [TIME_W-1:0]  rd_due;
  logic [ERR_W-1:0]   rd_err;
  logic [FAULT_W-1:0] rd_ft;

  logic               wr_en;
  logic               nused;
  logic [2:0]         nst;
  logic [2:0]         rep_st;
  logic [RETRY_W-1:0] nrt;
  logic [TIME_W-1:0]  ndue;
  logic [ERR_W-1:0]   nerr;
  logic [FAULT_W-1:0] nft;
  logic               done;
  logic               reinit;
  logic               exhausted;
  logic [RETRY_W:0]   tries;
  logic [TIME_W-1:0]  backoff;

  assign op = op_e'(req_i.operation);

  // Lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  assign in_range = (32'(req_i.slot) < SLOTS);
  assign idx      = (op == OP_REGISTER) ? free_idx : req_i.slot;
  assign hit      = (op == OP_REGISTER) ? free_found : in_range;

  assign rd_used = used_q[idx];
  assign rd_st   = status_q[idx];
  assign rd_rt   = retry_q[idx];
  assign rd_due  = due_q[idx];
  assign rd_err  = err_q[idx];
  assign rd_ft   = fault_q[idx];

  assign tries   = {1'b0, rd_rt} + 1'b1;
  assign backoff = TIME_W'({{(TIME_W-BACKOFF_W){1'b0}}, cfg_i.base_backoff_ms} << rd_rt);

  always_comb begin
    nused     = rd_used;
    nst       = rd_st;
    nrt       = rd_rt;
    ndue      = rd_due;
    nerr      = rd_err;
    nft       = rd_ft;
    done      = 1'b0;
    reinit    = 1'b0;
    exhausted = 1'b0;
    wr_en     = 1'b0;
    count_d   = count_q;
    rep_st    = rd_st;
    case (op)
      OP_REGISTER: begin
        if (free_found) begin
          wr_en   = 1'b1;
          done    = 1'b1;
          nused   = 1'b1;
          nst     = ST_UNKNOWN;
          nrt     = '0;
          ndue    = '0;
          nerr    = '0;
          count_d = count_q + 1'b1;
        end
      end
      OP_INIT: begin
        if (in_range && rd_used && (rd_st == ST_UNKNOWN || rd_st == ST_CONFIGURING)) begin
          wr_en = 1'b1;
          done  = 1'b1;
          if (req_i.init_ok) begin
            nst  = ST_AVAILABLE;
            nrt  = '0;
            ndue = '0;
            nerr = '0;
          end else begin
            nst  = ST_ERROR;
            nerr = req_i.error_code;
          end
        end
      end
      OP_CHECK: begin
        if (in_range && rd_used) begin
          wr_en = 1'b1;
          done  = 1'b1;
          if (rd_st == ST_UNAVAILABLE || rd_st == ST_ERROR) begin
            if (rd_rt < cfg_i.max_retries && req_i.current_time_ms >= rd_due) begin
              reinit = 1'b1;
              if (req_i.init_ok) begin
                nst  = ST_AVAILABLE;
                nrt  = '0;
                ndue = '0;
                nerr = '0;
              end else begin
                nrt  = tries[RETRY_W-1:0];
                nerr = req_i.error_code;
                ndue = req_i.current_time_ms + backoff;
                if (tries >= {1'b0, cfg_i.max_retries}) begin
                  exhausted = 1'b1;
                  nst       = ST_ERROR;
                  nft       = rd_ft + 1'b1;
                end
              end
            end
          end else if (rd_st == ST_AVAILABLE && !req_i.health_ok) begin
            nst  = ST_UNAVAILABLE;
            nrt  = '0;
            ndue = req_i.current_time_ms
                   + {{(TIME_W-BACKOFF_W){1'b0}}, cfg_i.base_backoff_ms};
          end
        end
      end
      OP_REMOVE: begin
        if (in_range && rd_used) begin
          wr_en   = 1'b1;
          done    = 1'b1;
          nused   = 1'b0;
          nst     = ST_EMPTY;
          nrt     = '0;
          ndue    = '0;
          nerr    = '0;
          count_d = count_q - 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (op == OP_REGISTER) begin
      rep_st = free_found ? ST_UNKNOWN : ST_EMPTY;
    end else if (op == OP_REMOVE && done) begin
      rep_st = ST_REMOVED;
    end else begin
      rep_st = nst;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= '0;
      count_q <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        status_q[i] <= ST_EMPTY;
        retry_q[i]  <= '0;
        due_q[i]    <= '0;
        err_q[i]    <= '0;
        fault_q[i]  <= '0;
      end
    end else if (fire_i && wr_en) begin
      used_q[idx]   <= nused;
      status_q[idx] <= nst;
      retry_q[idx]  <= nrt;
      due_q[idx]    <= ndue;
      err_q[idx]    <= nerr;
      fault_q[idx]  <= nft;
      count_q       <= count_d;
    end
  end

  always_comb begin
    rsp_o.result_slot       = idx;
    rsp_o.done_res          = done;
    rsp_o.old_state         = hit ? rd_st : ST_EMPTY;
    rsp_o.new_state         = hit ? rep_st : ST_EMPTY;
    rsp_o.reinit_attempted  = reinit;
    rsp_o.retries_exhausted = exhausted;
    rsp_o.retry_count       = hit ? nrt : '0;
    rsp_o.fault_count       = hit ? nft : '0;
    rsp_o.last_error        = hit ? nerr : '0;
    rsp_o.device_count      = count_d;
  end

endmodule

/* tb/dhrs_checker.sv */
// Checker: mirrors the slot table, predicts each result word and compares it.
module dhrs_checker
  import dhrs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  dhrs_req_if                   req_mon,
  dhrs_rsp_if                   rsp_mon,
  output int                    error_count_o,
  output int                    words_waiting_o,
  output int                    words_checked_o,
  output int                    reinit_seen_o,
  output int                    exhausted_seen_o,
  output int                    full_seen_o
);

  logic [RETRY_W-1:0]   lim_retries;
  logic [BACKOFF_W-1:0] backoff_base;
  logic                 occupied [SLOTS];
  state_e               status   [SLOTS];
  logic [RETRY_W-1:0]   tries    [SLOTS];
  logic [TIME_W-1:0]    due_ms   [SLOTS];
  logic [ERR_W-1:0]     err_rec  [SLOTS];
  logic [FAULT_W-1:0]   faults   [SLOTS];
  logic [COUNT_W-1:0]   live_total;
  dhrs_rsp_t            outcome_q [$];

  function automatic void clear_retry(input logic [SLOT_W-1:0] s);
    tries[s]   = '0;
    due_ms[s]  = '0;
    err_rec[s] = '0;
  endfunction

  // Apply one request word to the mirrored table and return the expected result word.
  function automatic dhrs_rsp_t supervise(input dhrs_req_t rq);
    dhrs_rsp_t         rs;
    logic [SLOT_W-1:0] s;
    logic              hit;
    logic              removed;
    logic [RETRY_W:0]  n;
    rs      = '0;
    s       = rq.slot;
    hit     = 1'b1;
    removed = 1'b0;
    if (op_e'(rq.operation) == OP_REGISTER) begin
      hit = 1'b0;
      s   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
        if (!occupied[i]) begin
          s   = SLOT_W'(i);
          hit = 1'b1;
        end
      end
      if (hit) begin
        rs.old_state = status[s];
        occupied[s]  = 1'b1;
        status[s]    = ST_UNKNOWN;
        clear_retry(s);
        live_total++;
        rs.done_res  = 1'b1;
        rs.new_state = ST_UNKNOWN;
      end
    end else begin
      rs.old_state = status[s];
      if (occupied[s]) begin
        case (op_e'(rq.operation))
          OP_INIT: begin
            if (status[s] == ST_UNKNOWN || status[s] == ST_CONFIGURING) begin
              rs.done_res = 1'b1;
              if (rq.init_ok) begin
                status[s] = ST_AVAILABLE;
                clear_retry(s);
              end else begin
                status[s]  = ST_ERROR;
                err_rec[s] = rq.error_code;
              end
            end
          end
          OP_CHECK: begin
            rs.done_res = 1'b1;
            if (status[s] == ST_UNAVAILABLE || status[s] == ST_ERROR) begin
              if (tries[s] < lim_retries && rq.current_time_ms >= due_ms[s]) begin
                rs.reinit_attempted = 1'b1;
                if (rq.init_ok) begin
                  status[s] = ST_AVAILABLE;
                  clear_retry(s);
                end else begin
                  n          = {1'b0, tries[s]} + 1'b1;
                  tries[s]   = n[RETRY_W-1:0];
                  err_rec[s] = rq.error_code;
                  // back off: base delay doubled per failed attempt before this one
                  due_ms[s]  = rq.current_time_ms + (TIME_W'(backoff_base) << (n - 1'b1));
                  if (n >= lim_retries) begin
                    rs.retries_exhausted = 1'b1;
                    status[s] = ST_ERROR;
                    faults[s] = faults[s] + 1'b1;
                  end
                end
              end
            end else if (status[s] == ST_AVAILABLE && !rq.health_ok) begin
              status[s] = ST_UNAVAILABLE;
              tries[s]  = '0;
              due_ms[s] = rq.current_time_ms + TIME_W'(backoff_base);
            end
          end
          default: begin
            rs.done_res = 1'b1;
            removed     = 1'b1;
            occupied[s] = 1'b0;
            status[s]   = ST_EMPTY;
            clear_retry(s);
            live_total--;
          end
        endcase
      end
      rs.new_state = removed ? ST_REMOVED : status[s];
    end
    rs.result_slot = s;
    if (hit) begin
      rs.retry_count = tries[s];
      rs.fault_count = faults[s];
      rs.last_error  = err_rec[s];
    end
    rs.device_count = live_total;
    return rs;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    error_count_o++;
    $display("%0t: check error on %s: got %0h, want %0h", $time, what, got, want);
  endtask

  task automatic check_word(input dhrs_rsp_t got, input dhrs_rsp_t want);
    if (got.result_slot !== want.result_slot)
      flag_mismatch("result_slot", got.result_slot, want.result_slot);
    if (got.done_res !== want.done_res)
      flag_mismatch("done_res", got.done_res, want.done_res);
    if (got.old_state !== want.old_state)
      flag_mismatch("old_state", got.old_state, want.old_state);
    if (got.new_state !== want.new_state)
      flag_mismatch("new_state", got.new_state, want.new_state);
    if (got.reinit_attempted !== want.reinit_attempted)
      flag_mismatch("reinit_attempted", got.reinit_attempted, want.reinit_attempted);
    if (got.retries_exhausted !== want.retries_exhausted)
      flag_mismatch("retries_exhausted", got.retries_exhausted, want.retries_exhausted);
    if (got.retry_count !== want.retry_count)
      flag_mismatch("retry_count", got.retry_count, want.retry_count);
    if (got.fault_count !== want.fault_count)
      flag_mismatch("fault_count", got.fault_count, want.fault_count);
    if (got.last_error !== want.last_error)
      flag_mismatch("last_error", got.last_error, want.last_error);
    if (got.device_count !== want.device_count)
      flag_mismatch("device_count", got.device_count, want.device_count);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    dhrs_rsp_t seen;
    dhrs_rsp_t want;
    dhrs_req_t rq;
    if (!rst_ni) begin
      lim_retries  = MaxRetriesRst;
      backoff_base = BaseBackoffRst;
      for (int i = 0; i < SLOTS; i++) begin
        occupied[i] = 1'b0;
        status[i]   = ST_EMPTY;
        tries[i]    = '0;
        due_ms[i]   = '0;
        err_rec[i]  = '0;
        faults[i]   = '0;
      end
      live_total = '0;
      outcome_q.delete();
      error_count_o    = 0;
      words_waiting_o  = 0;
      words_checked_o  = 0;
      reinit_seen_o    = 0;
      exhausted_seen_o = 0;
      full_seen_o      = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_MAX_RETRIES:  lim_retries  = cfg_wdata_i[RETRY_W-1:0];
          CFG_BASE_BACKOFF: backoff_base = cfg_wdata_i[BACKOFF_W-1:0];
          default: ;
        endcase
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        seen = {rsp_mon.result_slot, rsp_mon.done_res, rsp_mon.old_state,
                rsp_mon.new_state, rsp_mon.reinit_attempted, rsp_mon.retries_exhausted,
                rsp_mon.retry_count, rsp_mon.fault_count, rsp_mon.last_error,
                rsp_mon.device_count};
        if (outcome_q.size() == 0)
          flag_mismatch("result word with none outstanding", 32'(seen), 0);
        else check_word(seen, outcome_q.pop_front());
        words_checked_o++;
      end
      if (req_mon.valid && req_mon.ready) begin
        rq = {req_mon.operation, req_mon.slot, req_mon.current_time_ms, req_mon.health_ok,
              req_mon.init_ok, req_mon.error_code};
        want = supervise(rq);
        if (want.reinit_attempted) reinit_seen_o++;
        if (want.retries_exhausted) exhausted_seen_o++;
        if (op_e'(rq.operation) == OP_REGISTER && !want.done_res) full_seen_o++;
        outcome_q.push_back(want);
      end
      words_waiting_o = outcome_q.size();
    end
  end

endmodule

/* tb/tb.sv */
// Testbench top: drives request words and settings into the supervisor and gives the verdict.
module tb;
  import dhrs_pkg::*;

  localparam int unsigned WatchLimit = 2000;
  localparam int unsigned PhaseWords = 100;
  localparam int unsigned Phases     = 5;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  dhrs_req_if req_if ();
  dhrs_rsp_if rsp_if ();

  int error_count;
  int words_waiting;
  int words_checked;
  int reinit_seen;
  int exhausted_seen;
  int full_seen;
  int quiet_cycles = 0;
  int settings_used = 0;

  logic                 no_idle;
  logic [SLOTS-1:0]     live_mask;
  logic [TIME_W-1:0]    clock_ms;
  logic [BACKOFF_W-1:0] cur_backoff;

  device_health_retry_supervisor i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  dhrs_checker i_checker (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .req_mon          (req_if),
    .rsp_mon          (rsp_if),
    .error_count_o    (error_count),
    .words_waiting_o  (words_waiting),
    .words_checked_o  (words_checked),
    .reinit_seen_o    (reinit_seen),
    .exhausted_seen_o (exhausted_seen),
    .full_seen_o      (full_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    rsp_if.ready <= no_idle || ($urandom_range(0, 99) >= 36);
  end

  // End the run when no word moves on either channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic dhrs_req_t word_of(input op_e op, input logic [SLOT_W-1:0] slot,
                                        input logic [TIME_W-1:0] t, input logic hok,
                                        input logic iok, input logic [ERR_W-1:0] err);
    dhrs_req_t w;
    w.operation       = op;
    w.slot            = slot;
    w.current_time_ms = t;
    w.health_ok       = hok;
    w.init_ok         = iok;
    w.error_code      = err;
    return w;
  endfunction

  // Mostly address live slots and advance time past the backoff, with some noise.
  function automatic dhrs_req_t random_word();
    dhrs_req_t         w;
    int                pick;
    logic [SLOT_W-1:0] s;
    pick = $urandom_range(0, 99);
    w.operation = (pick < 15) ? OP_REGISTER : (pick < 35) ? OP_INIT :
                  (pick < 90) ? OP_CHECK : OP_REMOVE;
    s = SLOT_W'($urandom_range(0, SLOTS - 1));
    if (live_mask != '0 && $urandom_range(0, 99) < 85) begin
      while (!live_mask[s]) s = SLOT_W'($urandom_range(0, SLOTS - 1));
    end
    w.slot = s;
    pick = $urandom_range(0, 99);
    if (pick < 40) clock_ms = clock_ms + $urandom_range(0, TIME_W'(cur_backoff) << 1);
    else if (pick < 75) clock_ms = clock_ms + $urandom_range(0, TIME_W'(cur_backoff) << 7);
    else if (pick >= 93) clock_ms = 32'hFFFF_0000 | $urandom_range(0, 16'hFFFF);
    else if (pick >= 85) clock_ms = $urandom();
    w.current_time_ms = clock_ms;
    w.health_ok       = ($urandom_range(0, 99) < 60);
    w.init_ok         = 1'($urandom_range(0, 1));
    w.error_code      = ERR_W'($urandom_range(0, 16'hFFFF));
    return w;
  endfunction

  task automatic send_word(input dhrs_req_t w);
    int lowest;
    while (!no_idle && $urandom_range(0, 99) < 36) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid           <= 1'b1;
    req_if.operation       <= w.operation;
    req_if.slot            <= w.slot;
    req_if.current_time_ms <= w.current_time_ms;
    req_if.health_ok       <= w.health_ok;
    req_if.init_ok         <= w.init_ok;
    req_if.error_code      <= w.error_code;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
    // track which slots are live so later words can address them
    if (op_e'(w.operation) == OP_REGISTER) begin
      lowest = -1;
      for (int i = SLOTS - 1; i >= 0; i--) if (!live_mask[i]) lowest = i;
      if (lowest >= 0) live_mask[lowest] = 1'b1;
    end else if (op_e'(w.operation) == OP_REMOVE) begin
      live_mask[w.slot] = 1'b0;
    end
  endtask

  task automatic write_settings(input logic [RETRY_W-1:0] retries,
                                input logic [BACKOFF_W-1:0] backoff);
    req_if.valid <= 1'b0;
    while (words_waiting != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_MAX_RETRIES;
    cfg_wdata_i <= CFG_DATA_W'(retries);
    @(negedge clk_i);
    cfg_idx_i   <= CFG_BASE_BACKOFF;
    cfg_wdata_i <= backoff;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_backoff = backoff;
    settings_used++;
  endtask

  initial begin
    logic [RETRY_W-1:0]   phase_retries;
    logic [BACKOFF_W-1:0] phase_backoff;
    rst_ni                 = 1'b0;
    no_idle                = 1'b0;
    cfg_we_i               = 1'b0;
    cfg_idx_i              = '0;
    cfg_wdata_i            = '0;
    req_if.valid           = 1'b0;
    req_if.operation       = '0;
    req_if.slot            = '0;
    req_if.current_time_ms = '0;
    req_if.health_ok       = 1'b0;
    req_if.init_ok         = 1'b0;
    req_if.error_code      = '0;
    rsp_if.ready           = 1'b0;
    live_mask              = '0;
    clock_ms               = '0;
    cur_backoff            = BaseBackoffRst;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // fill the table, then one more register to hit the full case
    for (int i = 0; i < 17; i++) begin
      send_word(word_of(OP_REGISTER, SLOT_W'(i), '0, i[0], i[1], ERR_W'(i)));
    end
    send_word(word_of(OP_INIT, 4'd0, '0, 1'b1, 1'b1, 16'hFFFF));
    send_word(word_of(OP_INIT, 4'd1, '0, 1'b1, 1'b0, 16'hFFFF));
    send_word(word_of(OP_INIT, 4'd0, '0, 1'b1, 1'b0, 16'h1234));
    send_word(word_of(OP_CHECK, 4'd0, '0, 1'b0, 1'b1, 16'h0000));
    send_word(word_of(OP_CHECK, 4'd0, 32'd999, 1'b1, 1'b1, 16'h0000));
    // failed retry at the top of time: due stamp wraps
    send_word(word_of(OP_CHECK, 4'd1, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'h0000));
    send_word(word_of(OP_REMOVE, 4'd15, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'hFFFF));
    send_word(word_of(OP_CHECK, 4'd15, '0, 1'b0, 1'b1, 16'hFFFF));

    for (int p = 0; p < Phases; p++) begin
      case (p)
        0: begin phase_retries = 3'd1; phase_backoff = 16'd1; end
        1: begin phase_retries = 3'd7; phase_backoff = 16'hFFFF; end
        2: begin phase_retries = 3'd3; phase_backoff = 16'd1000; end
        3: begin phase_retries = 3'd2; phase_backoff = BACKOFF_W'($urandom_range(1, 300)); end
        default: begin
          phase_retries = RETRY_W'($urandom_range(1, 7));
          phase_backoff = BACKOFF_W'($urandom_range(1, 16'hFFFF));
        end
      endcase
      write_settings(phase_retries, phase_backoff);
      for (int k = 0; k < PhaseWords; k++) begin
        // hold both sides busy for a stretch in the middle phase
        no_idle = (p == 2 && k < 60);
        send_word(random_word());
      end
      no_idle = 1'b0;
    end

    req_if.valid <= 1'b0;
    while (words_waiting != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("Checked %0d result words under %0d settings: %0d reinits, %0d exhausted, %0d full",
             words_checked, settings_used + 1, reinit_seen, exhausted_seen, full_seen);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
